// ===== hw/rtl/grp_pkg.sv =====
// Package for the grid rectangle placement block: sizes, payload types and opcodes.
`default_nettype none
package grp_pkg;
   localparam int MaxColumnsDefault = 16;
   localparam int MaxRowsDefault    = 16;
   localparam int MaxIdsDefault     = 64;

   localparam logic [1:0] OP_PLACE  = 2'd0;
   localparam logic [1:0] OP_AUTO   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] item_id;
      logic [4:0] item_width;
      logic [4:0] item_height;
      logic [4:0] pos_x;
      logic [4:0] pos_y;
      logic       rotate;
   } req_type;

   typedef struct packed {
      logic       success;
      logic [3:0] placed_x;
      logic [3:0] placed_y;
      logic       placed_rotated;
      logic [5:0] cell_owner;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/grid_rectangle_placement.sv =====
// Top level of the grid rectangle placement block: cell memory and its sequencer.
// A query reads one cell; place, remove and auto add check the footprint cell by cell.
// A commit sweeps the cell memory and then fills one cell a cycle.
// Reset clears the cell memory in one pass with busy high.
// One item at a time; results are strobed for one cycle on rsp_valid; no stall.
`default_nettype none
module grid_rectangle_placement #(
   parameter int MAX_COLUMNS = grp_pkg::MaxColumnsDefault,
   parameter int MAX_ROWS    = grp_pkg::MaxRowsDefault,
   parameter int MAX_IDS     = grp_pkg::MaxIdsDefault
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  grp_pkg::req_type   req_item,
   output logic               rsp_valid,
   output grp_pkg::rsp_type   rsp_item,
   input  wire                csr_write,
   input  wire                csr_index,
   input  wire  [4:0]         csr_data
);
   import grp_pkg::*;

   localparam int Cells = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = $clog2(Cells + 1);
   localparam int IW    = $clog2(MAX_IDS);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_PREP   = 4'd2;
   localparam logic [3:0] ST_CHECK  = 4'd3;
   localparam logic [3:0] ST_WAIT   = 4'd4;
   localparam logic [3:0] ST_SWEEP  = 4'd5;
   localparam logic [3:0] ST_SWAIT  = 4'd6;
   localparam logic [3:0] ST_FILL   = 4'd7;
   localparam logic [3:0] ST_REMREC = 4'd8;
   localparam logic [3:0] ST_QWAIT  = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;
   localparam logic [3:0] ST_RCHK   = 4'd11;
   localparam logic [3:0] ST_RWAIT  = 4'd12;

   logic [5:0] cell_mem [Cells];
   logic [8:0] rec_mem [MAX_IDS];
   logic [MAX_IDS-1:0] rec_valid_ff;

   logic [3:0] state_ff;
   req_type    req_ff;
   logic [4:0] gw_ff, gh_ff;
   logic [4:0] cx_ff, cy_ff;       // corner under test
   logic [4:0] dx_ff, dy_ff;       // offset in footprint
   logic       pass_ff;
   logic [AW-1:0] sweep_ff;
   logic [5:0] rd_ff;
   logic [8:0] rec_rd_ff;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff;

   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [5:0]    wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) cell_mem[wr_addr[$clog2(Cells)-1:0]] <= wr_data;
      rd_ff <= cell_mem[rd_addr[$clog2(Cells)-1:0]];
   end

   logic [6:0] ew, eh;
   assign ew = ({2'b0, gw_ff} > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : {2'b0, gw_ff};
   assign eh = ({2'b0, gh_ff} > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : {2'b0, gh_ff};

   logic rot_eff;
   logic [4:0] sx, sy;
   logic id_ok;
   logic [IW-1:0] rid;
   assign rid = IW'(req_ff.item_id);
   assign id_ok = req_ff.item_id != 6'd0 && 32'(req_ff.item_id) < MAX_IDS;
   always_comb begin
      unique case (req_ff.operation)
         OP_PLACE:  rot_eff = req_ff.rotate;
         OP_AUTO:   rot_eff = pass_ff;
         default:   rot_eff = rec_rd_ff[0];
      endcase
      sx = rot_eff ? req_ff.item_height : req_ff.item_width;
      sy = rot_eff ? req_ff.item_width : req_ff.item_height;
   end

   logic in_grid;
   assign in_grid = ew != 0 && eh != 0 && sx != 0 && sy != 0 &&
                    (7'(cx_ff) + 7'(sx) <= ew) && (7'(cy_ff) + 7'(sy) <= eh);

   logic [13:0] cell_idx, query_idx;
   assign cell_idx  = 14'((7'(cy_ff) + 7'(dy_ff)) * ew) + 14'(cx_ff) + 14'(dx_ff);
   assign query_idx = 14'(req_ff.pos_y * ew) + 14'(req_ff.pos_x);

   logic last_cell;
   assign last_cell = (dx_ff + 5'd1 == sx) && (dy_ff + 5'd1 == sy);
   logic cell_clash;
   assign cell_clash = rd_ff != 6'd0 && rd_ff != req_ff.item_id;

   always_comb begin
      rd_addr = AW'(cell_idx);
      wr_en   = 1'b0;
      wr_addr = AW'(cell_idx);
      wr_data = req_ff.item_id;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1; wr_addr = sweep_ff; wr_data = 6'd0;
         end
         ST_SWEEP: rd_addr = sweep_ff;
         ST_SWAIT: begin
            wr_addr = sweep_ff - AW'(1);
            wr_en = rd_ff == req_ff.item_id;
            wr_data = 6'd0;
            rd_addr = sweep_ff;
         end
         ST_FILL: wr_en = 1'b1;
         ST_RWAIT: begin
            wr_addr = AW'(cell_idx);
            wr_en = rd_ff == req_ff.item_id;
            wr_data = 6'd0;
         end
         ST_PREP: rd_addr = AW'(query_idx);
         default: ;
      endcase
   end

   logic [3:0] state_in;
   logic [4:0] cx_in, cy_in, dx_in, dy_in;
   logic pass_in;
   logic [AW-1:0] sweep_in;
   rsp_type rsp_in;
   logic rsp_valid_in;

   always_comb begin
      state_in = state_ff; cx_in = cx_ff; cy_in = cy_ff; dx_in = dx_ff; dy_in = dy_ff;
      pass_in = pass_ff; sweep_in = sweep_ff; rsp_in = '0; rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(Cells - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (start) state_in = ST_PREP;
         ST_PREP: begin
            cx_in = req_ff.operation == OP_PLACE ? req_ff.pos_x : 5'd0;
            cy_in = req_ff.operation == OP_PLACE ? req_ff.pos_y : 5'd0;
            dx_in = 5'd0; dy_in = 5'd0; pass_in = 1'b0;
            unique case (req_ff.operation)
               OP_QUERY: state_in = ST_QWAIT;
               OP_REMOVE: state_in = id_ok ? ST_REMREC : ST_DONE;
               default: state_in = id_ok ? ST_CHECK : ST_DONE;
            endcase
         end
         ST_QWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.cell_owner = (query_idx < 14'(ew * eh)) ? rd_ff : 6'd0;
            state_in = ST_IDLE;
         end
         ST_CHECK: begin
            if (in_grid) state_in = ST_WAIT;
            else begin
               // Move to the next corner, or give up.
               dx_in = 5'd0; dy_in = 5'd0;
               if (req_ff.operation == OP_PLACE) state_in = ST_DONE;
               else if (7'(cx_ff) + 7'd1 < ew) cx_in = cx_ff + 5'd1;
               else if (7'(cy_ff) + 7'd1 < eh) begin cx_in = 5'd0; cy_in = cy_ff + 5'd1; end
               else if (!pass_ff) begin pass_in = 1'b1; cx_in = 5'd0; cy_in = 5'd0; end
               else state_in = ST_DONE;
               if (ew == 0 || eh == 0) state_in = ST_DONE;
            end
         end
         ST_WAIT: begin
            if (cell_clash) begin
               dx_in = 5'd0; dy_in = 5'd0;
               if (req_ff.operation == OP_PLACE) state_in = ST_DONE;
               else begin
                  state_in = ST_CHECK;
                  if (7'(cx_ff) + 7'd1 < ew) cx_in = cx_ff + 5'd1;
                  else if (7'(cy_ff) + 7'd1 < eh) begin cx_in = 5'd0; cy_in = cy_ff + 5'd1; end
                  else if (!pass_ff) begin pass_in = 1'b1; cx_in = 5'd0; cy_in = 5'd0; end
                  else state_in = ST_DONE;
               end
            end else if (last_cell) begin
               state_in = ST_SWEEP; sweep_in = '0; dx_in = 5'd0; dy_in = 5'd0;
            end else begin
               state_in = ST_CHECK;
               if (dx_ff + 5'd1 == sx) begin dx_in = 5'd0; dy_in = dy_ff + 5'd1; end
               else dx_in = dx_ff + 5'd1;
            end
         end
         ST_SWEEP: begin state_in = ST_SWAIT; sweep_in = sweep_ff + AW'(1); end
         ST_SWAIT: begin
            if (sweep_ff == AW'(Cells)) state_in = ST_FILL;
            else sweep_in = sweep_ff + AW'(1);
         end
         ST_FILL: begin
            if (last_cell) begin
               state_in = ST_IDLE; rsp_valid_in = 1'b1;
               rsp_in.success = 1'b1; rsp_in.placed_x = cx_ff[3:0];
               rsp_in.placed_y = cy_ff[3:0]; rsp_in.placed_rotated = rot_eff;
            end else if (dx_ff + 5'd1 == sx) begin dx_in = 5'd0; dy_in = dy_ff + 5'd1; end
            else dx_in = dx_ff + 5'd1;
         end
         ST_REMREC: begin
            if (!rec_valid_ff[rid]) state_in = ST_DONE;
            else begin
               cx_in = {1'b0, rec_rd_ff[8:5]}; cy_in = {1'b0, rec_rd_ff[4:1]};
               state_in = ST_RCHK;
            end
         end
         ST_RCHK: state_in = in_grid ? ST_RWAIT : ST_IDLE;
         ST_RWAIT: begin
            if (last_cell) state_in = ST_IDLE;
            else begin
               state_in = ST_RCHK;
               if (dx_ff + 5'd1 == sx) begin dx_in = 5'd0; dy_in = dy_ff + 5'd1; end
               else dx_in = dx_ff + 5'd1;
            end
         end
         ST_DONE: begin state_in = ST_IDLE; rsp_valid_in = 1'b1; end
         default: state_in = ST_IDLE;
      endcase
      // A remove that found its record reports success when it finishes.
      if ((state_ff == ST_RCHK || state_ff == ST_RWAIT) && state_in == ST_IDLE) begin
         rsp_valid_in = 1'b1; rsp_in.success = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) req_ff <= req_item;
      rec_rd_ff <= rec_mem[rid];
      if (state_ff == ST_FILL && last_cell)
         rec_mem[rid] <= {cx_ff[3:0], cy_ff[3:0], rot_eff};
      cx_ff <= cx_in; cy_ff <= cy_in; dx_ff <= dx_in; dy_ff <= dy_in;
      pass_ff <= pass_in; rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_CLEAR; sweep_ff <= '0; rsp_valid_ff <= 1'b0;
         rec_valid_ff <= '0; gw_ff <= 5'd0; gh_ff <= 5'd0;
      end else begin
         state_ff <= state_in; sweep_ff <= sweep_in; rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            if (csr_index == CSR_WIDTH) gw_ff <= csr_data;
            else gh_ff <= csr_data;
         end
         if (state_ff == ST_FILL && last_cell) rec_valid_ff[rid] <= 1'b1;
         if (state_ff == ST_REMREC && rec_valid_ff[rid]) rec_valid_ff[rid] <= 1'b0;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_IDLE) else $error("result outside idle");
   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=> !rsp_valid) else $error("result during clear");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item not taken");
endmodule
`default_nettype wire
